[rtl/wssm_pkg.sv]
// Shared types, constants and operation codes for the spot stability monitor.
// Used by the ring memory, the wide arithmetic unit and the top level.
package wssm_pkg;

  localparam int MAX_WINDOW = 256;
  localparam int MIN_WINDOW = 8;
  localparam int ADDR_W     = $clog2(MAX_WINDOW);
  localparam int LEN_W      = ADDR_W + 1;

  // Arithmetic widths
  localparam int WIDE_W = 128;   // operand width of the shared unit
  localparam int SUM_W  = 42;    // plain sums over the window
  localparam int PROD_W = 66;    // one 33 x 33 signed product
  localparam int ACC_W  = 76;    // sums of products over the window
  localparam int D_W    = 82;    // n*Sab - Sa*Sb
  localparam int SQ_W   = 80;    // Sx squared
  localparam int ROOT_W = 41;    // square root of a D term

  localparam logic [16:0] CORR_ONE = 17'd65536;

  // Register reset values
  localparam logic [LEN_W-1:0] RST_WINDOW_LENGTH = LEN_W'(64);
  localparam logic [31:0]      RST_CV_LIMIT      = 32'd983;
  localparam logic [16:0]      RST_LEAKAGE_LIMIT = 17'd45875;
  localparam logic [16:0]      RST_ELEC_LIMIT    = 17'd42598;
  localparam logic [16:0]      RST_THERMAL_LIMIT = 17'd45875;
  localparam logic [16:0]      RST_MIN_FIT       = 17'd60293;

  // Register indexes
  localparam logic [2:0] CFG_WINDOW_LENGTH = 3'd0;
  localparam logic [2:0] CFG_CV_LIMIT      = 3'd1;
  localparam logic [2:0] CFG_LEAKAGE_LIMIT = 3'd2;
  localparam logic [2:0] CFG_ELEC_LIMIT    = 3'd3;
  localparam logic [2:0] CFG_THERMAL_LIMIT = 3'd4;
  localparam logic [2:0] CFG_MIN_FIT       = 3'd5;

  // Flag bit positions
  localparam int FLG_UNSTABLE = 0;
  localparam int FLG_LEAKAGE  = 1;
  localparam int FLG_EMISSION = 2;
  localparam int FLG_KV       = 3;
  localparam int FLG_THERMAL  = 4;
  localparam int FLG_OPTICAL  = 5;
  localparam int FLG_QUALITY  = 6;
  localparam int FLG_NUMERIC  = 7;

  // Wide arithmetic unit operations
  localparam logic [1:0] OP_MUL  = 2'd0;
  localparam logic [1:0] OP_DIV  = 2'd1;
  localparam logic [1:0] OP_SQRT = 2'd2;

  typedef struct packed {
    logic [31:0]        spot;
    logic signed [31:0] leak;
    logic signed [31:0] cur;
    logic signed [32:0] kverr;
    logic signed [31:0] temp;
  } ring_entry_t;

  typedef struct packed {
    logic       start;
    logic [1:0] op;
  } wau_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } wau_stat_t;

endpackage

[rtl/window_spot_stability_monitor_top.sv]
// Top level of the spot stability monitor: sequencer, window sums, output register.
// Instantiates wssm_ring and wssm_wau; uses wssm_pkg.
//
//  channel | signals                              | transfer when
//  --------+--------------------------------------+----------------------
//  in      | in_valid, in_stall, sample fields    | in_valid & !in_stall
//  out     | out_valid, out_stall, result fields  | out_valid & !out_stall
//  cfg     | cfg_valid, cfg_ready, index, data    | cfg_valid & cfg_ready
//
// A rejected sample goes straight to the output register; an accepted sample
// before the window fills takes two squares and a 64-step root in the shared
// unit. With a full window, a sweep over the ring memory follows, then the
// 128-step divider and 64-step root of the shared unit finish the result.
// Reset clears control and counters; ring contents stay undefined until written.
// A result waits in the output register while the next transaction is taken.
module window_spot_stability_monitor_top import wssm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] kv_setpoint,
  input  logic signed [31:0] kv_actual,
  input  logic signed [31:0] tube_current,
  input  logic signed [31:0] return_residual,
  input  logic signed [31:0] temperature,
  input  logic signed [31:0] sigma_x,
  input  logic signed [31:0] sigma_y,
  input  logic signed [31:0] fit_r2,
  input  logic               all_valid,
  input  logic               non_finite,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         diag_flags,
  output logic [31:0]        spot_cv,
  output logic signed [17:0] corr_leakage,
  output logic signed [17:0] corr_current,
  output logic signed [17:0] corr_kv_error,
  output logic signed [17:0] corr_temperature,
  output logic [31:0]        accepted_total,
  output logic [31:0]        rejected_total,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_SQX  = 5'd1;
  localparam logic [4:0] ST_SQY  = 5'd2;
  localparam logic [4:0] ST_SPOT = 5'd3;
  localparam logic [4:0] ST_PASS = 5'd4;
  localparam logic [4:0] ST_DXA  = 5'd5;
  localparam logic [4:0] ST_DXB  = 5'd6;
  localparam logic [4:0] ST_CVA  = 5'd7;
  localparam logic [4:0] ST_CVB  = 5'd8;
  localparam logic [4:0] ST_CVC  = 5'd9;
  localparam logic [4:0] ST_CVD  = 5'd10;
  localparam logic [4:0] ST_SXR  = 5'd11;
  localparam logic [4:0] ST_YA   = 5'd12;
  localparam logic [4:0] ST_YB   = 5'd13;
  localparam logic [4:0] ST_XYA  = 5'd14;
  localparam logic [4:0] ST_XYB  = 5'd15;
  localparam logic [4:0] ST_YR   = 5'd16;
  localparam logic [4:0] ST_PR   = 5'd17;
  localparam logic [4:0] ST_PD   = 5'd18;
  localparam logic [4:0] ST_FLAG = 5'd19;
  localparam logic [4:0] ST_DONE = 5'd20;

  // Configuration
  logic [LEN_W-1:0] window_length;
  logic [31:0]      cv_limit;
  logic [16:0]      leakage_limit;
  logic [16:0]      electrical_limit;
  logic [16:0]      thermal_limit;
  logic [16:0]      min_fit_quality;

  // Window bookkeeping and counters
  logic [ADDR_W-1:0] write_pos;
  logic [LEN_W-1:0]  fill_count;
  logic [31:0]       accepted_ctr;
  logic [31:0]       rejected_ctr;

  logic [4:0] state;
  logic       issued;
  logic [1:0] k;

  // Sample held during the work
  logic [30:0]        sgx;
  logic [30:0]        sgy;
  logic signed [31:0] s_leak;
  logic signed [31:0] s_cur;
  logic signed [32:0] s_kverr;
  logic signed [31:0] s_temp;

  // Sweep pipeline
  logic [LEN_W-1:0]   rd_idx;
  logic               v1;
  logic               v2;
  ring_entry_t        rdata;
  logic signed [32:0] x_d;
  logic signed [32:0] y_d [4];
  logic signed [PROD_W-1:0] prod_xx;
  logic signed [PROD_W-1:0] prod_yy [4];
  logic signed [PROD_W-1:0] prod_xy [4];
  logic signed [SUM_W-1:0]  sx;
  logic signed [SUM_W-1:0]  sy [4];
  logic signed [ACC_W-1:0]  sxx;
  logic signed [ACC_W-1:0]  syy [4];
  logic signed [ACC_W-1:0]  sxy [4];

  // Final arithmetic
  logic [WIDE_W-1:0]   t_a;
  logic [WIDE_W-1:0]   t_b;
  logic [SQ_W-1:0]     sxsq;
  logic [D_W-1:0]      dxx;
  logic [D_W-1:0]      dyy;
  logic signed [D_W:0] dxy;
  logic [ROOT_W-1:0]   rx;
  logic [ROOT_W-1:0]   ry;

  // Result being built
  logic [7:0]         r_flags;
  logic [31:0]        r_cv;
  logic signed [17:0] r_corr [4];

  // Unit interface
  wau_req_t          wreq;
  wau_stat_t         wstat;
  logic [WIDE_W-1:0] wa;
  logic [WIDE_W-1:0] wb;
  logic [WIDE_W-1:0] wres;

  // Combinational helpers
  logic              in_take;
  logic              quality_ok;
  logic              cfg_we;
  logic [8:0]        cfg_len;
  logic [16:0]       cfg_v17;
  logic [ADDR_W-1:0] wr_p;
  logic [LEN_W-1:0]  wr_p_inc;
  logic [LEN_W-1:0]  fill_next;
  logic              mem_we;
  ring_entry_t       wdata;
  logic              issue;
  logic signed [SUM_W-1:0] sy_k;
  logic [SUM_W-1:0]  sy_abs;
  logic [D_W-1:0]    dxy_abs;
  logic [D_W-1:0]    dxx_new;
  logic [WIDE_W-1:0] t_sum;
  logic [16:0]       corr_mag;
  logic signed [17:0] corr_new;
  logic [7:0]        rej_flags;
  logic [16:0]       abs_c [4];
  logic [7:0]        flags_full;
  logic              out_load;

  assign in_stall  = (state != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_take   = in_valid && !in_stall;
  assign cfg_we    = cfg_valid && cfg_ready;

  assign quality_ok = all_valid && !non_finite &&
                      !(fit_r2 < $signed({15'b0, min_fit_quality})) &&
                      (sigma_x > 32'sd0) && (sigma_y > 32'sd0);

  assign cfg_len = cfg_data[8:0];
  assign cfg_v17 = cfg_data[16:0];

  // Ring write position and fill
  assign wr_p      = (LEN_W'(write_pos) < window_length) ? write_pos : '0;
  assign wr_p_inc  = LEN_W'(wr_p) + LEN_W'(1);
  assign fill_next = (fill_count < window_length) ? fill_count + LEN_W'(1) : fill_count;
  assign mem_we    = (state == ST_SPOT) && wstat.done;
  assign issue     = (state == ST_PASS) && (rd_idx < window_length);

  always_comb begin
    wdata.spot  = wres[31:0];
    wdata.leak  = s_leak;
    wdata.cur   = s_cur;
    wdata.kverr = s_kverr;
    wdata.temp  = s_temp;
  end

  wssm_ring u_ring (
    .clk   (clk),
    .we    (mem_we),
    .waddr (wr_p),
    .wdata (wdata),
    .raddr (rd_idx[ADDR_W-1:0]),
    .rdata (rdata)
  );

  wssm_wau u_wau (
    .clk    (clk),
    .rst    (rst),
    .req    (wreq),
    .opnd_a (wa),
    .opnd_b (wb),
    .stat   (wstat),
    .result (wres)
  );

  always_comb begin
    sy_k    = sy[k];
    sy_abs  = sy_k[SUM_W-1] ? SUM_W'(-sy_k) : SUM_W'(sy_k);
    dxy_abs = dxy[D_W] ? D_W'(-dxy) : D_W'(dxy);
    dxx_new = D_W'(t_a - wres);
    t_sum   = (t_a + wres) >> 1;
    corr_mag = (wres > WIDE_W'(CORR_ONE)) ? CORR_ONE : wres[16:0];
    corr_new = dxy[D_W] ? -$signed({1'b0, corr_mag}) : $signed({1'b0, corr_mag});
    rej_flags = '0;
    rej_flags[FLG_QUALITY] = 1'b1;
    rej_flags[FLG_NUMERIC] = non_finite;
  end

  // Operand selection for the shared unit
  always_comb begin
    wreq.start = 1'b0;
    wreq.op    = OP_MUL;
    wa         = '0;
    wb         = '0;
    case (state)
      ST_SQX: begin
        wreq.start = !issued;
        wa = WIDE_W'(sgx);
        wb = WIDE_W'(sgx);
      end
      ST_SQY: begin
        wreq.start = !issued;
        wa = WIDE_W'(sgy);
        wb = WIDE_W'(sgy);
      end
      ST_SPOT, ST_CVD: begin
        wreq.start = !issued;
        wreq.op    = OP_SQRT;
        wa = t_a;
      end
      ST_DXA: begin
        wreq.start = !issued;
        wa = WIDE_W'(sxx);
        wb = WIDE_W'(window_length);
      end
      ST_DXB: begin
        wreq.start = !issued;
        wa = WIDE_W'(sx);
        wb = WIDE_W'(sx);
      end
      ST_CVA: begin
        wreq.start = !issued;
        wa = WIDE_W'(dxx);
        wb = WIDE_W'(window_length);
      end
      ST_CVB: begin
        wreq.start = !issued;
        wa = WIDE_W'(sxsq);
        wb = WIDE_W'(window_length - LEN_W'(1));
      end
      ST_CVC: begin
        wreq.start = !issued;
        wreq.op    = OP_DIV;
        wa = t_a << 32;
        wb = t_b;
      end
      ST_SXR: begin
        wreq.start = !issued;
        wreq.op    = OP_SQRT;
        wa = WIDE_W'(dxx);
      end
      ST_YA: begin
        wreq.start = !issued;
        wa = WIDE_W'(syy[k]);
        wb = WIDE_W'(window_length);
      end
      ST_YB: begin
        wreq.start = !issued;
        wa = WIDE_W'(sy_abs);
        wb = WIDE_W'(sy_abs);
      end
      ST_XYA: begin
        wreq.start = !issued;
        wa = WIDE_W'(sxy[k]);
        wb = WIDE_W'(window_length);
      end
      ST_XYB: begin
        wreq.start = !issued;
        wa = WIDE_W'(sy_k);
        wb = WIDE_W'(sx);
      end
      ST_YR: begin
        wreq.start = !issued;
        wreq.op    = OP_SQRT;
        wa = WIDE_W'(dyy);
      end
      ST_PR: begin
        wreq.start = !issued;
        wa = WIDE_W'(rx);
        wb = WIDE_W'(ry);
      end
      ST_PD: begin
        wreq.start = !issued;
        wreq.op    = OP_DIV;
        wa = WIDE_W'(dxy_abs) << 16;
        wb = t_b;
      end
      default: begin
        wreq.start = 1'b0;
      end
    endcase
  end

  // Classification of an unstable spot
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      abs_c[i] = r_corr[i][17] ? 17'(-r_corr[i]) : 17'(r_corr[i]);
    end
    flags_full = '0;
    if (r_cv > cv_limit) begin
      flags_full[FLG_UNSTABLE] = 1'b1;
      flags_full[FLG_LEAKAGE]  = abs_c[0] >= leakage_limit;
      flags_full[FLG_EMISSION] = abs_c[1] >= electrical_limit;
      flags_full[FLG_KV]       = abs_c[2] >= electrical_limit;
      flags_full[FLG_THERMAL]  = abs_c[3] >= thermal_limit;
      flags_full[FLG_OPTICAL]  = (flags_full[4:1] == '0);
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      window_length    <= RST_WINDOW_LENGTH;
      cv_limit         <= RST_CV_LIMIT;
      leakage_limit    <= RST_LEAKAGE_LIMIT;
      electrical_limit <= RST_ELEC_LIMIT;
      thermal_limit    <= RST_THERMAL_LIMIT;
      min_fit_quality  <= RST_MIN_FIT;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WINDOW_LENGTH: begin
          if (cfg_len < 9'(MIN_WINDOW)) begin
            window_length <= LEN_W'(MIN_WINDOW);
          end else if (cfg_len > 9'(MAX_WINDOW)) begin
            window_length <= LEN_W'(MAX_WINDOW);
          end else begin
            window_length <= LEN_W'(cfg_len);
          end
        end
        CFG_CV_LIMIT:      cv_limit <= cfg_data;
        CFG_LEAKAGE_LIMIT:
          leakage_limit <= (cfg_v17 > CORR_ONE) ? RST_LEAKAGE_LIMIT : cfg_v17;
        CFG_ELEC_LIMIT:
          electrical_limit <= (cfg_v17 > CORR_ONE) ? RST_ELEC_LIMIT : cfg_v17;
        CFG_THERMAL_LIMIT:
          thermal_limit <= (cfg_v17 > CORR_ONE) ? RST_THERMAL_LIMIT : cfg_v17;
        CFG_MIN_FIT:
          min_fit_quality <= (cfg_v17 > CORR_ONE) ? RST_MIN_FIT : cfg_v17;
        default: ;
      endcase
    end
  end

  // Sweep pipeline: registered read, products, then accumulate
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= issue;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (v1) begin
      x_d     <= $signed({1'b0, rdata.spot});
      y_d[0]  <= 33'(rdata.leak);
      y_d[1]  <= 33'(rdata.cur);
      y_d[2]  <= rdata.kverr;
      y_d[3]  <= 33'(rdata.temp);
      prod_xx <= $signed({1'b0, rdata.spot}) * $signed({1'b0, rdata.spot});
      prod_yy[0] <= 33'(rdata.leak) * 33'(rdata.leak);
      prod_yy[1] <= 33'(rdata.cur) * 33'(rdata.cur);
      prod_yy[2] <= rdata.kverr * rdata.kverr;
      prod_yy[3] <= 33'(rdata.temp) * 33'(rdata.temp);
      prod_xy[0] <= $signed({1'b0, rdata.spot}) * 33'(rdata.leak);
      prod_xy[1] <= $signed({1'b0, rdata.spot}) * 33'(rdata.cur);
      prod_xy[2] <= $signed({1'b0, rdata.spot}) * rdata.kverr;
      prod_xy[3] <= $signed({1'b0, rdata.spot}) * 33'(rdata.temp);
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      issued       <= 1'b0;
      write_pos    <= '0;
      fill_count   <= '0;
      accepted_ctr <= '0;
      rejected_ctr <= '0;
      rd_idx       <= '0;
      k            <= '0;
    end else begin
      if (wreq.start) issued <= 1'b1;
      if (wstat.done) issued <= 1'b0;

      if (cfg_we && cfg_index == CFG_WINDOW_LENGTH) begin
        write_pos  <= '0;
        fill_count <= '0;
      end

      case (state)
        ST_IDLE: begin
          if (in_take) begin
            sgx     <= sigma_x[30:0];
            sgy     <= sigma_y[30:0];
            s_leak  <= return_residual;
            s_cur   <= tube_current;
            s_kverr <= 33'(kv_actual) - 33'(kv_setpoint);
            s_temp  <= temperature;
            r_cv    <= '0;
            for (int i = 0; i < 4; i++) r_corr[i] <= '0;
            if (quality_ok) begin
              r_flags <= '0;
              state   <= ST_SQX;
            end else begin
              rejected_ctr <= rejected_ctr + 32'(rejected_ctr != '1);
              r_flags <= rej_flags;
              state <= ST_DONE;
            end
          end
        end
        ST_SQX: if (wstat.done) begin
          t_a   <= wres;
          state <= ST_SQY;
        end
        ST_SQY: if (wstat.done) begin
          t_a   <= t_sum;
          state <= ST_SPOT;
        end
        ST_SPOT: if (wstat.done) begin
          write_pos    <= (wr_p_inc == window_length) ? '0 : wr_p_inc[ADDR_W-1:0];
          fill_count   <= fill_next;
          accepted_ctr <= accepted_ctr + 32'(accepted_ctr != '1);
          rd_idx <= '0;
          sx     <= '0;
          sxx    <= '0;
          for (int i = 0; i < 4; i++) begin
            sy[i]  <= '0;
            syy[i] <= '0;
            sxy[i] <= '0;
          end
          state <= (fill_next >= window_length) ? ST_PASS : ST_DONE;
        end
        ST_PASS: begin
          if (issue) rd_idx <= rd_idx + LEN_W'(1);
          if (v2) begin
            sx  <= sx + SUM_W'(x_d);
            sxx <= sxx + ACC_W'(prod_xx);
            for (int i = 0; i < 4; i++) begin
              sy[i]  <= sy[i] + SUM_W'(y_d[i]);
              syy[i] <= syy[i] + ACC_W'(prod_yy[i]);
              sxy[i] <= sxy[i] + ACC_W'(prod_xy[i]);
            end
          end
          if (!issue && !v1 && !v2) state <= ST_DXA;
        end
        ST_DXA: if (wstat.done) begin
          t_a   <= wres;
          state <= ST_DXB;
        end
        ST_DXB: if (wstat.done) begin
          sxsq <= wres[SQ_W-1:0];
          dxx  <= dxx_new;
          // no spot variance: cv and all correlations stay zero
          state <= (dxx_new == '0) ? ST_FLAG : ST_CVA;
        end
        ST_CVA: if (wstat.done) begin
          t_a   <= wres;
          state <= ST_CVB;
        end
        ST_CVB: if (wstat.done) begin
          t_b   <= wres;
          state <= ST_CVC;
        end
        ST_CVC: if (wstat.done) begin
          t_a   <= wres;
          state <= ST_CVD;
        end
        ST_CVD: if (wstat.done) begin
          r_cv  <= (wres[WIDE_W-1:32] != '0) ? '1 : wres[31:0];
          state <= ST_SXR;
        end
        ST_SXR: if (wstat.done) begin
          rx    <= wres[ROOT_W-1:0];
          k     <= '0;
          state <= ST_YA;
        end
        ST_YA: if (wstat.done) begin
          t_a   <= wres;
          state <= ST_YB;
        end
        ST_YB: if (wstat.done) begin
          dyy   <= dxx_new;
          state <= ST_XYA;
        end
        ST_XYA: if (wstat.done) begin
          t_a   <= wres;
          state <= ST_XYB;
        end
        ST_XYB: if (wstat.done) begin
          dxy <= (D_W+1)'(t_a - wres);
          if (dyy == '0) begin
            k     <= k + 2'd1;
            state <= (k == 2'd3) ? ST_FLAG : ST_YA;
          end else begin
            state <= ST_YR;
          end
        end
        ST_YR: if (wstat.done) begin
          ry    <= wres[ROOT_W-1:0];
          state <= ST_PR;
        end
        ST_PR: if (wstat.done) begin
          t_b   <= wres;
          state <= ST_PD;
        end
        ST_PD: if (wstat.done) begin
          r_corr[k] <= corr_new;
          k     <= k + 2'd1;
          state <= (k == 2'd3) ? ST_FLAG : ST_YA;
        end
        ST_FLAG: begin
          r_flags <= flags_full;
          state   <= ST_DONE;
        end
        ST_DONE: begin
          if (out_load) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Output register
  assign out_load = (state == ST_DONE) && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      diag_flags       <= r_flags;
      spot_cv          <= r_cv;
      corr_leakage     <= r_corr[0];
      corr_current     <= r_corr[1];
      corr_kv_error    <= r_corr[2];
      corr_temperature <= r_corr[3];
      accepted_total   <= accepted_ctr;
      rejected_total   <= rejected_ctr;
    end
  end

endmodule

[rtl/wssm_ring.sv]
// Window storage: one entry per accepted sample, five fields side by side.
// Synchronous memory, one write and one registered read port; uses wssm_pkg.
module wssm_ring import wssm_pkg::*; (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  ring_entry_t       wdata,
  input  logic [ADDR_W-1:0] raddr,
  output ring_entry_t       rdata
);

  ring_entry_t mem [MAX_WINDOW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[rtl/wssm_wau.sv]
// Shared wide arithmetic unit: shift-add multiply, restoring divide and
// bit-pair square root over 128-bit operands, one step per cycle. Uses wssm_pkg.
module wssm_wau import wssm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  wau_req_t          req,
  input  logic [WIDE_W-1:0] opnd_a,
  input  logic [WIDE_W-1:0] opnd_b,
  output wau_stat_t         stat,
  output logic [WIDE_W-1:0] result
);

  logic [1:0]        op;
  logic              busy;
  logic              done;
  logic [WIDE_W-1:0] acc;
  logic [WIDE_W-1:0] opa;
  logic [WIDE_W-1:0] opb;
  logic [WIDE_W:0]   rem;
  logic [6:0]        cnt;

  logic [WIDE_W:0] div_sh;
  logic            div_ge;
  logic [67:0]     sq_sh;
  logic [67:0]     sq_trial;
  logic            sq_ge;

  always_comb begin
    div_sh   = {rem[WIDE_W-1:0], opa[WIDE_W-1]};
    div_ge   = div_sh >= {1'b0, opb};
    sq_sh    = {rem[65:0], opa[WIDE_W-1 -: 2]};
    sq_trial = {2'b00, acc[63:0], 2'b01};
    sq_ge    = sq_sh >= sq_trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        busy <= 1'b1;
        op   <= req.op;
        opa  <= opnd_a;
        opb  <= opnd_b;
        acc  <= '0;
        rem  <= '0;
        cnt  <= (req.op == OP_SQRT) ? 7'd63 : 7'd127;
      end else if (busy) begin
        case (op)
          OP_MUL: begin
            // stop as soon as the multiplier runs out of ones
            if (opb == '0) begin
              busy <= 1'b0;
              done <= 1'b1;
            end else begin
              if (opb[0]) acc <= acc + opa;
              opa <= opa << 1;
              opb <= opb >> 1;
            end
          end
          OP_DIV: begin
            rem <= div_ge ? div_sh - {1'b0, opb} : div_sh;
            opa <= {opa[WIDE_W-2:0], div_ge};
            cnt <= cnt - 7'd1;
            if (cnt == '0) begin
              busy <= 1'b0;
              done <= 1'b1;
            end
          end
          OP_SQRT: begin
            rem <= {{(WIDE_W-67){1'b0}}, (sq_ge ? sq_sh - sq_trial : sq_sh)};
            acc <= {acc[WIDE_W-2:0], sq_ge};
            opa <= opa << 2;
            cnt <= cnt - 7'd1;
            if (cnt == '0) begin
              busy <= 1'b0;
              done <= 1'b1;
            end
          end
          default: begin
            busy <= 1'b0;
            done <= 1'b1;
          end
        endcase
      end
    end
  end

  always_comb begin
    stat.busy = busy;
    stat.done = done;
    if (op == OP_DIV) begin
      result = (opb == '0) ? '0 : opa;
    end else begin
      result = acc;
    end
  end

endmodule

[rtl/wssm_checker.sv]
// Port-level checks for the spot stability monitor top level.
// Attached by the bind at the end of this file; uses no package.
module wssm_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_stall,
  input logic [7:0]         diag_flags,
  input logic [31:0]        spot_cv,
  input logic signed [17:0] corr_leakage,
  input logic signed [17:0] corr_current,
  input logic signed [17:0] corr_kv_error,
  input logic signed [17:0] corr_temperature
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(diag_flags) && $stable(spot_cv))
    else $error("stalled result changed");

  // Rejected samples carry no statistics
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && diag_flags[6] |-> spot_cv == 32'd0 && corr_leakage == 18'sd0 &&
      corr_current == 18'sd0 && corr_kv_error == 18'sd0 && corr_temperature == 18'sd0)
    else $error("rejected sample reports statistics");

  // Cause flags only accompany an unstable spot
  a_cause_needs_unstable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !diag_flags[0] |-> diag_flags[5:1] == 5'd0)
    else $error("cause flag without unstable flag");

  // Leakage and temperature correlations stay within [-1, 1]
  a_corr_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> corr_leakage <= 18'sd65536 && corr_leakage >= -18'sd65536 &&
      corr_temperature <= 18'sd65536 && corr_temperature >= -18'sd65536)
    else $error("correlation out of range");

endmodule

bind window_spot_stability_monitor_top wssm_checker u_wssm_checker (
  .clk              (clk),
  .rst              (rst),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .diag_flags       (diag_flags),
  .spot_cv          (spot_cv),
  .corr_leakage     (corr_leakage),
  .corr_current     (corr_current),
  .corr_kv_error    (corr_kv_error),
  .corr_temperature (corr_temperature)
);
